FILE: rtl/sorted_insert_two_key_table_defines.svh
// ----------------------------------------------------------------------------
// Sorted insert two-key table: assertion macros
// Shared assertion forms for the table's modules, clocked on clk and
// disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef SORTED_INSERT_TWO_KEY_TABLE_DEFINES_SVH
`define SORTED_INSERT_TWO_KEY_TABLE_DEFINES_SVH

// Property that holds at every clock edge outside reset.
`define STIT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define STIT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/stit_pkg.sv
// ----------------------------------------------------------------------------
// Sorted insert two-key table: package
// Field widths and the command and status groups between controller and
// datapath.
// ----------------------------------------------------------------------------
package stit_pkg;

	localparam int LETTER_BITS = 8;
	localparam int RESULT_BITS = 5;

	typedef struct packed {
		logic load;
		logic compare;
		logic commit;
	} stit_cmd_t;

	typedef struct packed {
		logic out_free;
	} stit_sts_t;

endpackage

FILE: rtl/stit_if.sv
// ----------------------------------------------------------------------------
// Sorted insert two-key table: channel interfaces
// Valid/ready channels for insert requests and their results.
// ----------------------------------------------------------------------------
interface stit_in_if #(
	parameter int WEIGHT_BITS = 32
);
	import stit_pkg::*;

	logic                          valid;
	logic                          ready;
	logic [LETTER_BITS-1:0]        letter;
	logic signed [WEIGHT_BITS-1:0] weight;

	modport source (output valid, output letter, output weight, input ready);
	modport sink (input valid, input letter, input weight, output ready);
endinterface

interface stit_out_if;
	import stit_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [RESULT_BITS-1:0] position;
	logic [RESULT_BITS-1:0] fill;
	logic                   dropped;

	modport source (output valid, output position, output fill, output dropped, input ready);
	modport sink (input valid, input position, input fill, input dropped, output ready);
endinterface

FILE: rtl/stit_ctrl.sv
// ----------------------------------------------------------------------------
// Sorted insert two-key table: controller
// Sequences each item through load, compare and commit, and holds the
// commit until the result register is free.
// ----------------------------------------------------------------------------
`include "sorted_insert_two_key_table_defines.svh"

module stit_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  stit_pkg::stit_sts_t sts,
	output stit_pkg::stit_cmd_t cmd
);
	import stit_pkg::*;

	localparam logic [1:0] ST_IDLE    = 2'd0;
	localparam logic [1:0] ST_COMPARE = 2'd1;
	localparam logic [1:0] ST_COMMIT  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		cmd         = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_COMPARE;
				end
			end
			ST_COMPARE: begin
				cmd.compare = 1'b1;
				state_d     = ST_COMMIT;
			end
			ST_COMMIT: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`STIT_ASSERT_NEXT(a_load_then_compare, cmd.load, cmd.compare,
		"A loaded item did not reach the compare step.")
	`STIT_ASSERT(a_commit_needs_room, !cmd.commit || sts.out_free,
		"Commit issued while the result register was occupied.")
	`STIT_ASSERT_NEXT(a_commit_then_ready, cmd.commit, in_ready,
		"The controller did not return to accepting items after a commit.")

endmodule

FILE: rtl/stit_dp.sv
// ----------------------------------------------------------------------------
// Sorted insert two-key table: datapath
// Holds the sorted row of entries, compares the new item against every
// entry at once, shifts the row on commit and keeps the result register.
// ----------------------------------------------------------------------------
`include "sorted_insert_two_key_table_defines.svh"

module stit_dp #(
	parameter int TABLE_DEPTH = 16,
	parameter int WEIGHT_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  stit_pkg::stit_cmd_t                 cmd,
	output stit_pkg::stit_sts_t                 sts,
	input  logic [stit_pkg::LETTER_BITS-1:0]    in_letter,
	input  logic signed [WEIGHT_BITS-1:0]       in_weight,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [stit_pkg::RESULT_BITS-1:0]    out_position,
	output logic [stit_pkg::RESULT_BITS-1:0]    out_fill,
	output logic                                out_dropped
);
	import stit_pkg::*;

	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

	logic [LETTER_BITS-1:0]        letter_q;
	logic signed [WEIGHT_BITS-1:0] weight_q;
	logic [TABLE_DEPTH-1:0]        less_q;
	logic [TABLE_DEPTH-1:0]        less_d;
	logic [CW-1:0]                 count_q;
	logic [CW-1:0]                 count_d;
	logic [CW-1:0]                 pos_d;
	logic                          full;
	logic                          insert;

	logic [LETTER_BITS-1:0]        ent_letter_q [TABLE_DEPTH];
	logic signed [WEIGHT_BITS-1:0] ent_weight_q [TABLE_DEPTH];

	logic                          out_valid_q;
	logic [RESULT_BITS-1:0]        out_position_q;
	logic [RESULT_BITS-1:0]        out_fill_q;
	logic                          out_dropped_q;

	assign full   = (count_q == DEPTH_C);
	assign insert = cmd.commit && (pos_d != DEPTH_C);
	assign sts.out_free = !out_valid_q || out_ready;

	always_comb begin
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			less_d[i] = (CW'(i) < count_q) &&
				((ent_letter_q[i] < letter_q) ||
				 ((ent_letter_q[i] == letter_q) && (ent_weight_q[i] < weight_q)));
		end
	end

	// The valid part of the row is sorted, so the smaller entries form a prefix.
	always_comb begin
		pos_d = DEPTH_C;
		for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
			if (!less_q[i]) begin
				pos_d = CW'(i);
			end
		end
	end

	assign count_d = full ? count_q : count_q + 1'b1;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			letter_q <= in_letter;
			weight_q <= in_weight;
		end
		if (cmd.compare) begin
			less_q <= less_d;
		end
	end

	for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
		if (g == 0) begin : g_head
			always_ff @(posedge clk) begin
				if (insert && (pos_d == '0)) begin
					ent_letter_q[g] <= letter_q;
					ent_weight_q[g] <= weight_q;
				end
			end
		end else begin : g_body
			always_ff @(posedge clk) begin
				if (insert) begin
					if (pos_d == CW'(g)) begin
						ent_letter_q[g] <= letter_q;
						ent_weight_q[g] <= weight_q;
					end else if (pos_d < CW'(g)) begin
						ent_letter_q[g] <= ent_letter_q[g-1];
						ent_weight_q[g] <= ent_weight_q[g-1];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (insert) begin
				count_q <= count_d;
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_position_q <= RESULT_BITS'(pos_d);
			out_fill_q     <= RESULT_BITS'(count_d);
			out_dropped_q  <= full;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_position = out_position_q;
	assign out_fill     = out_fill_q;
	assign out_dropped  = out_dropped_q;

	`STIT_ASSERT(a_count_bounded, count_q <= DEPTH_C,
		"Fill count exceeds the table depth.")
	`STIT_ASSERT_NEXT(a_full_stays_full, cmd.commit && full, count_q == DEPTH_C,
		"A full table lost an entry on insert.")
	`STIT_ASSERT_NEXT(a_grow_by_one, cmd.commit && !full,
		count_q == CW'($past(count_q) + 1'b1),
		"Insert into a table with room did not grow it by one entry.")

endmodule

FILE: rtl/sorted_insert_two_key_table.sv
// ----------------------------------------------------------------------------
// Sorted insert two-key table: top level
// Keeps up to TABLE_DEPTH entries in ascending order by letter, then by
// signed weight, and reports for each insert its position, the new fill and
// whether the largest entry fell off a full table.
// ----------------------------------------------------------------------------
// Each item is captured on acceptance, compared against every stored entry at
// once in the next cycle, and then committed in the commit state, when the
// row shifts and the result register loads. The commit waits while the result
// register still holds an unread result, but a new item can be accepted while
// an earlier result waits to be taken. A new entry goes ahead of any equal
// one; on a full table the largest entry is discarded, and if that is the new
// one the position reads as TABLE_DEPTH and the table is left as it was.
module sorted_insert_two_key_table #(
	parameter int TABLE_DEPTH = 16,
	parameter int WEIGHT_BITS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	stit_in_if.sink    req,
	stit_out_if.source rsp
);
	import stit_pkg::*;

	stit_cmd_t cmd;
	stit_sts_t sts;

	stit_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	stit_dp #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.in_letter    (req.letter),
		.in_weight    (req.weight),
		.out_valid    (rsp.valid),
		.out_ready    (rsp.ready),
		.out_position (rsp.position),
		.out_fill     (rsp.fill),
		.out_dropped  (rsp.dropped)
	);

endmodule
